// ----- sv/mpq_pkg.sv -----
package mpq_pkg;

	// queue geometry
	localparam int DEPTH       = 64;
	localparam int HANDLE_BITS = 9;
	localparam int KEY_W       = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CAP_W       = 7;
	localparam int OCC_W       = 7;
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// reset value of the capacity register
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// input word packing: key, then handle, padded to whole bytes
	localparam int IN_BITS  = KEY_W + HANDLE_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

	// output word packing: key, handle, empty, full, occupancy
	localparam int OUT_BITS = KEY_W + HANDLE_BITS + 2 + OCC_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// operation codes carried in s_tuser
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t ent;
	} cell_ctl_t;

endpackage

// ----- sv/mpq_cell.sv -----
module mpq_cell
	import mpq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  entry_t    prev_ent,
	input  logic      prev_le,
	input  entry_t    next_ent,
	output entry_t    ent,
	output logic      le
);

	entry_t ent_q;
	entry_t ent_d;

	// this cell keeps its entry on insert when its key is not above the new one
	assign le  = occupied && (ent_q.key <= ctl.ent.key);
	assign ent = ent_q;

	// next entry: keep, take the new one, shift from the left or from the right
	always_comb begin
		ent_d = ent_q;
		if (ctl.ins && !le) begin
			if (prev_le) begin
				ent_d = ctl.ent;
			end else begin
				ent_d = prev_ent;
			end
		end else if (ctl.rem) begin
			ent_d = next_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

// ----- sv/min_priority_queue_top.sv -----
// channel  | dir | signals                          | word
// s_       | in  | s_tvalid s_tready s_tdata s_tuser | one insert or remove
// m_       | out | m_tvalid m_tready m_tdata m_tuser | one result per operation
// cfg_     | in  | cfg_valid cfg_ready cfg_data     | capacity register write
//
// the whole cell row compares against the new key and shifts together, so a
// new word is taken in every cycle while s_tready is high.
// the result sits in an output register from the cycle after acceptance.
// s_tready drops only while a result waits and m_tready is low.
// arst_n clears the count, the result valid flag and sets capacity to 64;
// cell contents are not reset, the count marks which cells hold entries.
module min_priority_queue_top
	import mpq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_W-1:0]    s_tdata,  // entry_key, entry_handle, zero pad
	input  logic               s_tuser,  // action
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,  // out_key, out_handle, now_empty, now_full,
	                                     // occupancy, zero pad
	output logic               m_tuser,  // accepted
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CAP_W-1:0]   cfg_data  // capacity_in_use
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CMP_W-1:0] eff_cap;
	logic [CMP_W-1:0] count_ext;
	logic [CMP_W-1:0] count_d_ext;
	logic             take;
	logic             is_rem;
	logic             ins_ok;
	logic             rem_ok;
	cell_ctl_t        ctl;
	entry_t           new_ent;

	entry_t           cell_ent [DEPTH];
	logic   [DEPTH-1:0] cell_le;
	logic   [DEPTH-1:0] occ;

	logic               m_tvalid_q;
	logic               acc_q;
	entry_t             res_ent_q;
	logic               empty_q;
	logic               full_q;
	logic [OCC_W-1:0]   occ_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign take      = s_tvalid && s_tready;
	assign is_rem    = (op_t'(s_tuser) == OP_REMOVE);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// effective capacity limited to the cell count
	assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
	assign count_ext = CMP_W'(count_q);
	assign ins_ok    = !is_rem && (count_ext < eff_cap);
	assign rem_ok    = is_rem && (count_q != '0);

	assign new_ent.key    = s_tdata[KEY_W-1:0];
	assign new_ent.handle = s_tdata[KEY_W +: HANDLE_BITS];

	assign ctl.ins = take && ins_ok;
	assign ctl.rem = take && rem_ok;
	assign ctl.ent = new_ent;

	// count update
	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end
	assign count_d_ext = CMP_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// row of sorted cells, smallest key in cell zero
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_l;

			assign occ[gi] = (count_q > CNT_W'(gi));

			if (gi == 0) begin : g_first
				assign prev_e = new_ent;
				assign prev_l = 1'b1;
			end else begin : g_mid
				assign prev_e = cell_ent[gi-1];
				assign prev_l = cell_le[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign next_e = '0;
			end else begin : g_inner
				assign next_e = cell_ent[gi+1];
			end

			mpq_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occupied (occ[gi]),
				.prev_ent (prev_e),
				.prev_le  (prev_l),
				.next_ent (next_e),
				.ent      (cell_ent[gi]),
				.le       (cell_le[gi])
			);
		end
	endgenerate

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			acc_q     <= ins_ok || rem_ok;
			res_ent_q <= rem_ok ? cell_ent[0] : '0;
			empty_q   <= (count_d == '0);
			full_q    <= (count_d_ext >= eff_cap);
			occ_q     <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = acc_q;
	assign m_tdata  = OUT_W'({occ_q, full_q, empty_q, res_ent_q.handle, res_ent_q.key});

endmodule
